/* src/lda_gibbs_topic_resampler_defines.svh */
// assertion macros for the resampler rtl, used by the back end
`ifndef LDA_GIBBS_TOPIC_RESAMPLER_DEFINES_SVH
`define LDA_GIBBS_TOPIC_RESAMPLER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define LGT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgt assertion failed");

// next-cycle implication
`define LGT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgt assertion failed");

`endif

/* src/lgt_pkg.sv */
// shared constants, types and codes for the lda topic resampler
`default_nettype none
package lgt_pkg;

   localparam int MAX_DOCS   = 256;
   localparam int MAX_TERMS  = 1024;
   localparam int MAX_TOPICS = 16;

   localparam int DOC_W    = $clog2(MAX_DOCS);
   localparam int TERM_W   = $clog2(MAX_TERMS);
   localparam int TOPIC_W  = $clog2(MAX_TOPICS);
   localparam int TOPIC1_W = $clog2(MAX_TOPICS + 1);

   // port field widths
   localparam int DOC_IN_W    = 8;
   localparam int TERM_IN_W   = 10;
   localparam int INIT_IN_W   = 4;
   localparam int U_W         = 16;
   localparam int OUT_TOPIC_W = 5;
   localparam int STATUS_W    = 2;

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int Q_W          = 16;
   localparam int TOPICS_REG_W = 5;
   localparam int VOC_W        = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOPICS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOCAB  = 2'd3;

   localparam logic [Q_W-1:0]          ALPHA_RESET  = 16'd256;
   localparam logic [Q_W-1:0]          BETA_RESET   = 16'd26;
   localparam logic [TOPICS_REG_W-1:0] TOPICS_RESET = 5'd16;
   localparam logic [VOC_W-1:0]        VOCAB_RESET  = 11'd1024;

   localparam logic CMD_INIT     = 1'b0;
   localparam logic CMD_RESAMPLE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PRIOR   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 2'd2;

   // count tables
   localparam int CELL_W = TOPIC1_W;
   localparam int DT_W   = 11;
   localparam int TT_W   = 9;
   localparam int TOT_W  = 19;
   localparam logic [DT_W-1:0]  DT_MAX  = '1;
   localparam logic [TT_W-1:0]  TT_MAX  = '1;
   localparam logic [TOT_W-1:0] TOT_MAX = '1;

   localparam int CELL_AW = DOC_W + TERM_W;
   localparam int DT_AW   = DOC_W + TOPIC_W;
   localparam int TT_AW   = TOPIC_W + TERM_W;

   // weight datapath
   localparam int A_W    = TT_W + 9;
   localparam int B_W    = DT_W + 9;
   localparam int PROD_W = A_W + B_W;
   localparam int NUM_W  = PROD_W + 8;
   localparam int BV_W   = Q_W + VOC_W;
   localparam int DEN_W  = TOT_W + 9;
   localparam int W_W    = 32;
   localparam int SUM_W  = W_W + TOPIC_W;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [Q_W-1:0]      alpha;
      logic [Q_W-1:0]      beta;
      logic [TOPIC1_W-1:0] k;
      logic [VOC_W-1:0]    v;
   } lgt_cfg_type;

   typedef struct packed {
      logic               cmd;
      logic [DOC_W-1:0]   doc;
      logic [TERM_W-1:0]  term;
      logic               present;
      logic               in_range;
      logic [TOPIC_W-1:0] init_topic;
      logic [U_W-1:0]     u;
   } lgt_item_type;

endpackage
`default_nettype wire

/* src/lgt_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module lgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* src/lgt_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module lgt_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [lgt_pkg::NUM_W-1:0] num,
   input  wire logic [lgt_pkg::DEN_W-1:0] den,
   output logic                           done,
   output logic      [lgt_pkg::NUM_W-1:0] quo
);
   import lgt_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] nq_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, nq_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
            rem_ff  <= '0;
            nq_ff   <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
            nq_ff  <= {nq_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = nq_ff;

endmodule
`default_nettype wire

/* src/lgt_front.sv */
// front end: config registers, item classification and the command queue
`default_nettype none
module lgt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [lgt_pkg::DOC_IN_W-1:0]  req_doc_index,
   input  wire logic [lgt_pkg::TERM_IN_W-1:0] req_term_index,
   input  wire logic                          req_word_present,
   input  wire logic [lgt_pkg::INIT_IN_W-1:0] req_init_topic,
   input  wire logic [lgt_pkg::U_W-1:0]       req_uniform_draw,
   input  wire logic                          csr_wr_en,
   input  wire logic [lgt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lgt_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                          clearing,
   output lgt_pkg::lgt_cfg_type               cfg,
   output logic                               q_valid,
   output lgt_pkg::lgt_item_type              q_item,
   input  wire logic                          q_pop
);
   import lgt_pkg::*;

   localparam int QAW   = $clog2(QUEUE_DEPTH);
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

   logic [Q_W-1:0]          alpha_ff;
   logic [Q_W-1:0]          beta_ff;
   logic [TOPICS_REG_W-1:0] topics_ff;
   logic [VOC_W-1:0]        vocab_ff;

   lgt_item_type            q_ff [QUEUE_DEPTH];
   logic [QAW-1:0]          wr_ptr_ff;
   logic [QAW-1:0]          rd_ptr_ff;
   logic [QCW-1:0]          count_ff;

   lgt_item_type            item;
   logic [TOPIC1_W-1:0]     k_eff;
   logic                    push;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         beta_ff   <= BETA_RESET;
         topics_ff <= TOPICS_RESET;
         vocab_ff  <= VOCAB_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_ff  <= csr_wdata[Q_W-1:0];
            CSR_BETA:   beta_ff   <= csr_wdata[Q_W-1:0];
            CSR_TOPICS: topics_ff <= csr_wdata[TOPICS_REG_W-1:0];
            CSR_VOCAB:  vocab_ff  <= csr_wdata[VOC_W-1:0];
            default: ;
         endcase
      end
   end

   // zero topics acts as one, above the built maximum saturates
   always_comb begin
      if (topics_ff == '0) begin
         k_eff = TOPIC1_W'(1);
      end else if (int'(topics_ff) > MAX_TOPICS) begin
         k_eff = TOPIC1_W'(MAX_TOPICS);
      end else begin
         k_eff = TOPIC1_W'(topics_ff);
      end
   end

   always_comb begin
      cfg.alpha = alpha_ff;
      cfg.beta  = beta_ff;
      cfg.k     = k_eff;
      cfg.v     = (int'(vocab_ff) > MAX_TERMS) ? VOC_W'(MAX_TERMS) : vocab_ff;
   end

   always_comb begin
      item.cmd        = req_command;
      item.doc        = DOC_W'(req_doc_index);
      item.term       = TERM_W'(req_term_index);
      item.present    = req_word_present;
      item.in_range   = (int'(req_doc_index) < MAX_DOCS) && (int'(req_term_index) < MAX_TERMS);
      item.init_topic = (int'(req_init_topic) < int'(k_eff)) ? TOPIC_W'(req_init_topic)
                                                              : TOPIC_W'(k_eff - TOPIC1_W'(1));
      item.u          = req_uniform_draw;
   end

   assign busy = clearing || (count_ff == QCW'(QUEUE_DEPTH));
   assign push = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         if (push && !q_pop) begin
            count_ff <= count_ff + QCW'(1);
         end else if (q_pop && !push) begin
            count_ff <= count_ff - QCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_valid = count_ff != '0;
   assign q_item  = q_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* src/lgt_back.sv */
// back end: count tables, weight loop, inverse cdf search and result beat
`default_nettype none
`include "lda_gibbs_topic_resampler_defines.svh"
module lgt_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  lgt_pkg::lgt_cfg_type                 cfg,
   input  wire logic                            q_valid,
   input  lgt_pkg::lgt_item_type                q_item,
   output logic                                 q_pop,
   output logic                                 clearing,
   output logic                                 rsp_strobe,
   output logic [lgt_pkg::OUT_TOPIC_W-1:0]      rsp_new_topic,
   output logic [lgt_pkg::OUT_TOPIC_W-1:0]      rsp_old_topic,
   output logic [lgt_pkg::STATUS_W-1:0]         rsp_status
);
   import lgt_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_OLD, S_REM_RD, S_REM_WR, S_CHOOSE,
      S_W_RD, S_W_MUL, S_W_DIV, S_TARGET, S_SEARCH, S_ADD_RD, S_ADD_WR
   } state_type;

   state_type            state_ff;
   logic [CELL_AW-1:0]   clr_ff;
   lgt_item_type         item_ff;
   logic [TOPIC_W-1:0]   idx_ff;
   logic [CELL_W-1:0]    old_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [TOT_W-1:0]     tot_ff [MAX_TOPICS];
   logic [W_W-1:0]       w_ff [MAX_TOPICS];
   logic [BV_W-1:0]      bv_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [DEN_W-1:0]     den_ff;
   logic                 div_go_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     run_ff;
   logic [SUM_W-1:0]     target_ff;
   logic                 rsp_strobe_ff;
   logic [OUT_TOPIC_W-1:0] rsp_new_ff;
   logic [OUT_TOPIC_W-1:0] rsp_old_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic                 cell_we;
   logic [CELL_AW-1:0]   cell_wa;
   logic [CELL_W-1:0]    cell_wd;
   logic [CELL_AW-1:0]   cell_ra;
   logic [CELL_W-1:0]    cell_rd;
   logic                 dt_we;
   logic [DT_AW-1:0]     dt_wa;
   logic [DT_W-1:0]      dt_wd;
   logic [DT_AW-1:0]     dt_ra;
   logic [DT_W-1:0]      dt_rd;
   logic                 tt_we;
   logic [TT_AW-1:0]     tt_wa;
   logic [TT_W-1:0]      tt_wd;
   logic [TT_AW-1:0]     tt_ra;
   logic [TT_W-1:0]      tt_rd;

   logic                 div_done;
   logic [NUM_W-1:0]     div_quo;
   logic [W_W-1:0]       w_sat;
   logic [TOT_W-1:0]     tot_cur;
   logic [A_W-1:0]       a_term;
   logic [B_W-1:0]       b_term;
   logic [DEN_W-1:0]     den_raw;
   logic [SUM_W+U_W-1:0] draw_prod;
   logic [SUM_W-1:0]     run_next;
   logic                 last_topic;
   logic [CELL_W-1:0]    topic_one;

   lgt_ram #(.WIDTH(CELL_W), .DEPTH(MAX_DOCS * MAX_TERMS)) u_cell_ram (
      .clock(clock), .wr_en(cell_we), .wr_addr(cell_wa), .wr_data(cell_wd),
      .rd_addr(cell_ra), .rd_data(cell_rd)
   );

   lgt_ram #(.WIDTH(DT_W), .DEPTH(MAX_DOCS * MAX_TOPICS)) u_dt_ram (
      .clock(clock), .wr_en(dt_we), .wr_addr(dt_wa), .wr_data(dt_wd),
      .rd_addr(dt_ra), .rd_data(dt_rd)
   );

   lgt_ram #(.WIDTH(TT_W), .DEPTH(MAX_TOPICS * MAX_TERMS)) u_tt_ram (
      .clock(clock), .wr_en(tt_we), .wr_addr(tt_wa), .wr_data(tt_wd),
      .rd_addr(tt_ra), .rd_data(tt_rd)
   );

   lgt_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff),
      .num({prod_ff, 8'd0}), .den(den_ff), .done(div_done), .quo(div_quo)
   );

   assign tot_cur    = tot_ff[idx_ff];
   assign topic_one  = CELL_W'(idx_ff) + CELL_W'(1);
   assign last_topic = (TOPIC1_W'(idx_ff) == cfg.k - TOPIC1_W'(1));
   assign a_term     = A_W'({tt_rd, 8'd0}) + A_W'(cfg.beta);
   assign b_term     = B_W'({dt_rd, 8'd0}) + B_W'(cfg.alpha);
   assign den_raw    = DEN_W'({tot_cur, 8'd0}) + DEN_W'(bv_ff);
   assign w_sat      = (div_quo[NUM_W-1:W_W] != '0) ? '1 : div_quo[W_W-1:0];
   assign draw_prod  = sum_ff * item_ff.u;
   assign run_next   = run_ff + SUM_W'(w_ff[idx_ff]);

   assign cell_ra = {item_ff.doc, item_ff.term};
   assign dt_ra   = {item_ff.doc, idx_ff};
   assign tt_ra   = {idx_ff, item_ff.term};

   always_comb begin
      cell_we = 1'b0;
      cell_wa = cell_ra;
      cell_wd = topic_one;
      dt_we   = 1'b0;
      dt_wa   = dt_ra;
      dt_wd   = (dt_rd < DT_MAX) ? dt_rd + DT_W'(1) : dt_rd;
      tt_we   = 1'b0;
      tt_wa   = tt_ra;
      tt_wd   = (tt_rd < TT_MAX) ? tt_rd + TT_W'(1) : tt_rd;
      case (state_ff)
         S_CLEAR: begin
            cell_we = 1'b1;
            cell_wa = clr_ff;
            cell_wd = '0;
            dt_we   = 1'b1;
            dt_wa   = clr_ff[DT_AW-1:0];
            dt_wd   = '0;
            tt_we   = 1'b1;
            tt_wa   = clr_ff[TT_AW-1:0];
            tt_wd   = '0;
         end
         S_REM_WR: begin
            // an empty count stays at zero
            dt_we = 1'b1;
            dt_wd = (dt_rd == '0) ? dt_rd : dt_rd - DT_W'(1);
            tt_we = 1'b1;
            tt_wd = (tt_rd == '0) ? tt_rd : tt_rd - TT_W'(1);
         end
         S_ADD_WR: begin
            cell_we = 1'b1;
            dt_we   = 1'b1;
            tt_we   = 1'b1;
         end
         default: ;
      endcase
   end

   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign clearing = (state_ff == S_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         div_go_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         tot_ff        <= '{default: '0};
      end else begin
         div_go_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CELL_AW'(1);
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               state_ff <= S_OLD;
            end
            S_OLD: begin
               old_ff    <= item_ff.in_range ? cell_rd : '0;
               status_ff <= ST_OK;
               if (!item_ff.present || !item_ff.in_range) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_new_ff    <= '0;
                  rsp_old_ff    <= item_ff.in_range ? OUT_TOPIC_W'(cell_rd) : '0;
                  rsp_status_ff <= ST_OK;
                  state_ff      <= S_IDLE;
               end else if (cell_rd != '0) begin
                  idx_ff   <= TOPIC_W'(cell_rd - CELL_W'(1));
                  state_ff <= S_REM_RD;
               end else begin
                  status_ff <= (item_ff.cmd == CMD_RESAMPLE) ? ST_NO_PRIOR : ST_OK;
                  state_ff  <= S_CHOOSE;
               end
            end
            S_REM_RD: begin
               state_ff <= S_REM_WR;
            end
            S_REM_WR: begin
               if (dt_rd == '0 || tt_rd == '0 || tot_cur == '0) begin
                  status_ff <= ST_ZERO_COUNT;
               end
               if (tot_cur != '0) begin
                  tot_ff[idx_ff] <= tot_cur - TOT_W'(1);
               end
               state_ff <= S_CHOOSE;
            end
            S_CHOOSE: begin
               bv_ff <= cfg.beta * cfg.v;
               if (item_ff.cmd == CMD_INIT) begin
                  idx_ff   <= item_ff.init_topic;
                  state_ff <= S_ADD_RD;
               end else begin
                  idx_ff   <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_W_RD;
               end
            end
            S_W_RD: begin
               state_ff <= S_W_MUL;
            end
            S_W_MUL: begin
               prod_ff   <= a_term * b_term;
               den_ff    <= (den_raw == '0) ? DEN_W'(1) : den_raw;
               div_go_ff <= 1'b1;
               state_ff  <= S_W_DIV;
            end
            S_W_DIV: begin
               if (div_done) begin
                  w_ff[idx_ff] <= w_sat;
                  sum_ff       <= sum_ff + SUM_W'(w_sat);
                  if (last_topic) begin
                     state_ff <= S_TARGET;
                  end else begin
                     idx_ff   <= idx_ff + TOPIC_W'(1);
                     state_ff <= S_W_RD;
                  end
               end
            end
            S_TARGET: begin
               target_ff <= draw_prod[SUM_W+U_W-1:U_W];
               run_ff    <= '0;
               idx_ff    <= '0;
               state_ff  <= S_SEARCH;
            end
            S_SEARCH: begin
               run_ff <= run_next;
               if (run_next > target_ff) begin
                  state_ff <= S_ADD_RD;
               end else if (last_topic) begin
                  // no running sum passed the target: first topic
                  idx_ff   <= '0;
                  state_ff <= S_ADD_RD;
               end else begin
                  idx_ff <= idx_ff + TOPIC_W'(1);
               end
            end
            S_ADD_RD: begin
               state_ff <= S_ADD_WR;
            end
            S_ADD_WR: begin
               if (tot_cur < TOT_MAX) begin
                  tot_ff[idx_ff] <= tot_cur + TOT_W'(1);
               end
               rsp_strobe_ff <= 1'b1;
               rsp_new_ff    <= OUT_TOPIC_W'(topic_one);
               rsp_old_ff    <= OUT_TOPIC_W'(old_ff);
               rsp_status_ff <= status_ff;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_new_topic = rsp_new_ff;
   assign rsp_old_topic = rsp_old_ff;
   assign rsp_status    = rsp_status_ff;

   `LGT_ASSERT_NEXT(a_single_beat, rsp_strobe_ff, !rsp_strobe_ff)
   `LGT_ASSERT_NOW(a_new_within_k, rsp_strobe_ff, int'(rsp_new_ff) <= int'(cfg.k))
   `LGT_ASSERT_NOW(a_no_prior_empty, rsp_strobe_ff && rsp_status_ff == ST_NO_PRIOR, rsp_old_ff == '0)
   `LGT_ASSERT_NOW(a_absent_no_topic, rsp_strobe_ff && rsp_new_ff == '0, rsp_status_ff == ST_OK)

endmodule
`default_nettype wire

/* src/lda_gibbs_topic_resampler.sv */
// from the accepting edge to rsp_strobe: initialize and absent word items skip the weight loop,
// an occupied cell first passes S_REM_RD and S_REM_WR; resample computes one weight per topic
// in the divider, then searches the topics in order; one item in the back end at a time, queue of two
// reset: synchronous; config registers go to their defaults and a clearing pass over every cell
// address zeroes the cell and count memories, busy held high all that time
`default_nettype none
module lda_gibbs_topic_resampler (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_command,
   input  wire logic [lgt_pkg::DOC_IN_W-1:0]   req_doc_index,
   input  wire logic [lgt_pkg::TERM_IN_W-1:0]  req_term_index,
   input  wire logic                           req_word_present,
   input  wire logic [lgt_pkg::INIT_IN_W-1:0]  req_init_topic,
   input  wire logic [lgt_pkg::U_W-1:0]        req_uniform_draw,
   output logic                                rsp_strobe,
   output logic [lgt_pkg::OUT_TOPIC_W-1:0]     rsp_new_topic,
   output logic [lgt_pkg::OUT_TOPIC_W-1:0]     rsp_old_topic,
   output logic [lgt_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic                           csr_wr_en,
   input  wire logic [lgt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lgt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lgt_pkg::*;

   lgt_cfg_type  cfg;
   lgt_item_type q_item;
   logic         q_valid;
   logic         q_pop;
   logic         clearing;

   lgt_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_doc_index(req_doc_index),
      .req_term_index(req_term_index), .req_word_present(req_word_present),
      .req_init_topic(req_init_topic), .req_uniform_draw(req_uniform_draw),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .clearing(clearing), .cfg(cfg), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   lgt_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .clearing(clearing), .rsp_strobe(rsp_strobe),
      .rsp_new_topic(rsp_new_topic), .rsp_old_topic(rsp_old_topic), .rsp_status(rsp_status)
   );

endmodule
`default_nettype wire
